### sv/smp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_pkg: shared types, codes and microprogram of the stable matching block
// Holds the control word layout, the datapath operation and branch condition
// codes, the stream action codes and the microcode table itself.
// ----------------------------------------------------------------------------
package smp_pkg;

    // sizes fixed by the stream format
    localparam int DEF_MAX_PEOPLE = 16;
    localparam int CHOICE_W       = 4;
    localparam int PAIR_CNT_W     = 5;
    localparam logic [PAIR_CNT_W-1:0] PAIR_CNT_RESET = 5'd16;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 8;

    // action codes carried on s_tuser
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_LOAD_MAN   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_WOMAN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUN        = 2'd2;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE    = 4'd0;
    localparam logic [OP_W-1:0] OP_INIT    = 4'd1;
    localparam logic [OP_W-1:0] OP_START   = 4'd2;
    localparam logic [OP_W-1:0] OP_PROPOSE = 4'd3;
    localparam logic [OP_W-1:0] OP_ANSWER  = 4'd4;
    localparam logic [OP_W-1:0] OP_SCAN    = 4'd5;
    localparam logic [OP_W-1:0] OP_COMPARE = 4'd6;
    localparam logic [OP_W-1:0] OP_NEXT    = 4'd7;
    localparam logic [OP_W-1:0] OP_EMIT    = 4'd8;

    // branch conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] CND_ALWAYS    = 3'd0;
    localparam logic [COND_W-1:0] CND_RUN       = 3'd1;
    localparam logic [COND_W-1:0] CND_MAN_DONE  = 3'd2;
    localparam logic [COND_W-1:0] CND_ANSWERED  = 3'd3;
    localparam logic [COND_W-1:0] CND_SCAN_END  = 3'd4;
    localparam logic [COND_W-1:0] CND_DECIDED   = 3'd5;
    localparam logic [COND_W-1:0] CND_LAST_MAN  = 3'd6;
    localparam logic [COND_W-1:0] CND_EMIT_LAST = 3'd7;

    // microprogram step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] ST_INIT    = 4'd1;
    localparam logic [STEP_W-1:0] ST_START   = 4'd2;
    localparam logic [STEP_W-1:0] ST_TEST    = 4'd3;
    localparam logic [STEP_W-1:0] ST_ANSWER  = 4'd4;
    localparam logic [STEP_W-1:0] ST_SCAN    = 4'd5;
    localparam logic [STEP_W-1:0] ST_COMPARE = 4'd6;
    localparam logic [STEP_W-1:0] ST_NEXT    = 4'd7;
    localparam logic [STEP_W-1:0] ST_EMIT    = 4'd8;

    // one control word: operation, branch condition, taken / not taken targets
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] jt;
        logic [STEP_W-1:0] jf;
    } uword_t;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic run;
        logic man_done;
        logic answered;
        logic scan_end;
        logic decided;
        logic last_man;
        logic emit_last;
    } flags_t;

    // microcode table
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            ST_IDLE:    w = '{OP_IDLE,    CND_RUN,       ST_INIT,  ST_IDLE};
            ST_INIT:    w = '{OP_INIT,    CND_ALWAYS,    ST_START, ST_START};
            ST_START:   w = '{OP_START,   CND_ALWAYS,    ST_TEST,  ST_TEST};
            ST_TEST:    w = '{OP_PROPOSE, CND_MAN_DONE,  ST_NEXT,  ST_ANSWER};
            ST_ANSWER:  w = '{OP_ANSWER,  CND_ANSWERED,  ST_TEST,  ST_SCAN};
            ST_SCAN:    w = '{OP_SCAN,    CND_SCAN_END,  ST_TEST,  ST_COMPARE};
            ST_COMPARE: w = '{OP_COMPARE, CND_DECIDED,   ST_TEST,  ST_SCAN};
            ST_NEXT:    w = '{OP_NEXT,    CND_LAST_MAN,  ST_EMIT,  ST_START};
            ST_EMIT:    w = '{OP_EMIT,    CND_EMIT_LAST, ST_IDLE,  ST_EMIT};
            default:    w = '{OP_IDLE,    CND_ALWAYS,    ST_IDLE,  ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### sv/smp_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_sequencer: microprogram step counter
// Reads the control word of the current step from the microcode table and
// picks the next step from the branch condition the word selects.
// ----------------------------------------------------------------------------
module smp_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  smp_pkg::flags_t flags,
    output smp_pkg::uword_t uword
);
    import smp_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              cond_hit;

    assign uword = ucode_rom(step_reg);

    // branch condition select
    always_comb begin
        case (uword.cond)
            CND_ALWAYS:    cond_hit = 1'b1;
            CND_RUN:       cond_hit = flags.run;
            CND_MAN_DONE:  cond_hit = flags.man_done;
            CND_ANSWERED:  cond_hit = flags.answered;
            CND_SCAN_END:  cond_hit = flags.scan_end;
            CND_DECIDED:   cond_hit = flags.decided;
            CND_LAST_MAN:  cond_hit = flags.last_man;
            CND_EMIT_LAST: cond_hit = flags.emit_last;
            default:       cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? uword.jt : uword.jf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### sv/smp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_datapath: preference stores, engagement state and stream ports
// Executes one operation per cycle as the control word directs: list loads,
// proposals, the rank scan of a woman's list, and emission of the pairs.
// ----------------------------------------------------------------------------
module smp_datapath #(
    parameter int MAX_PEOPLE = smp_pkg::DEF_MAX_PEOPLE
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  smp_pkg::uword_t                 uword,
    output smp_pkg::flags_t                 flags,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [smp_pkg::PAIR_CNT_W-1:0]  cfg_data,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smp_pkg::S_TDATA_W-1:0]   s_tdata,   // person, rank_slot, choice
    input  logic [smp_pkg::ACT_W-1:0]       s_tuser,   // action
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smp_pkg::M_TDATA_W-1:0]   m_tdata,   // man_index, woman_index
    output logic                            m_tlast    // last_pair
);
    import smp_pkg::*;

    localparam int PW    = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int NW    = $clog2(MAX_PEOPLE + 1);
    localparam int DEPTH = MAX_PEOPLE * MAX_PEOPLE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (NW > CHOICE_W) ? NW : CHOICE_W;
    localparam logic [5:0]    MAX6 = 6'(MAX_PEOPLE);
    localparam logic [NW-1:0] MAXN = NW'(MAX_PEOPLE);
    localparam logic [AW-1:0] MAXA = AW'(MAX_PEOPLE);

    // preference stores
    logic [CHOICE_W-1:0] man_mem   [DEPTH];
    logic [CHOICE_W-1:0] woman_mem [DEPTH];

    // registers
    logic [PAIR_CNT_W-1:0] pc_reg,     pc_next;
    logic [NW-1:0]         n_reg,      n_next;
    logic [PW-1:0]         outer_reg,  outer_next;
    logic [PW-1:0]         m_reg,      m_next;
    logic [PW-1:0]         w_reg,      w_next;
    logic [PW-1:0]         h_reg,      h_next;
    logic [NW-1:0]         pos_reg,    pos_next;
    logic [NW-1:0]         np_reg [MAX_PEOPLE];
    logic [NW-1:0]         np_next [MAX_PEOPLE];
    logic                  hv_reg [MAX_PEOPLE];
    logic                  hv_next [MAX_PEOPLE];
    logic [PW-1:0]         hb_reg [MAX_PEOPLE];
    logic [PW-1:0]         hb_next [MAX_PEOPLE];
    logic                  wv_reg [MAX_PEOPLE];
    logic                  wv_next [MAX_PEOPLE];
    logic [PW-1:0]         wf_reg [MAX_PEOPLE];
    logic [PW-1:0]         wf_next [MAX_PEOPLE];
    logic [CHOICE_W-1:0]   man_rd_reg;
    logic [CHOICE_W-1:0]   woman_rd_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg,  m_tdata_next;
    logic                  m_tlast_reg,  m_tlast_next;

    // combinational helpers
    logic [CHOICE_W-1:0] ld_person, ld_slot, ld_choice;
    logic                ld_fits, in_beat;
    logic                ld_man_we, ld_woman_we;
    logic [AW-1:0]       ld_addr, prop_addr, scan_addr;
    logic                prop_en, scan_en;
    logic [NW-1:0]       n_calc;
    logic [PW-1:0]       w_idx;
    logic                w_out, man_done, scan_end, match_m, match_h;
    logic                last_man, out_free;
    logic [CW-1:0]       wife_wide, man_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = (uword.op == OP_IDLE);
    assign in_beat   = s_tvalid && s_tready;

    assign ld_person = s_tdata[3:0];
    assign ld_slot   = s_tdata[7:4];
    assign ld_choice = s_tdata[11:8];

    // loads outside the store are dropped
    assign ld_fits     = ({2'b00, ld_person} < MAX6) && ({2'b00, ld_slot} < MAX6);
    assign ld_man_we   = in_beat && ld_fits && (s_tuser == ACT_LOAD_MAN);
    assign ld_woman_we = in_beat && ld_fits && (s_tuser == ACT_LOAD_WOMAN);
    assign ld_addr     = AW'(ld_person) * MAXA + AW'(ld_slot);

    // clamp of the pair count to 1..MAX_PEOPLE
    always_comb begin
        if (pc_reg == '0) begin
            n_calc = NW'(1);
        end else if ({1'b0, pc_reg} > MAX6) begin
            n_calc = MAXN;
        end else begin
            n_calc = NW'(pc_reg);
        end
    end

    // status terms
    assign man_done  = wv_reg[m_reg] || (np_reg[m_reg] >= n_reg);
    assign prop_en   = (uword.op == OP_PROPOSE) && !man_done;
    assign prop_addr = AW'(m_reg) * MAXA + AW'(np_reg[m_reg]);
    assign w_idx     = PW'(man_rd_reg);
    assign w_out     = CW'(man_rd_reg) >= CW'(n_reg);
    assign scan_end  = pos_reg >= n_reg;
    assign scan_en   = (uword.op == OP_SCAN) && !scan_end;
    assign scan_addr = AW'(w_reg) * MAXA + AW'(pos_reg);
    assign match_m   = CW'(woman_rd_reg) == CW'(m_reg);
    assign match_h   = CW'(woman_rd_reg) == CW'(h_reg);
    assign last_man  = (NW'(outer_reg) + NW'(1)) == n_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign wife_wide = wv_reg[outer_reg] ? CW'(wf_reg[outer_reg]) : '0;
    assign man_wide  = CW'(outer_reg);

    always_comb begin
        flags.run       = in_beat && (s_tuser == ACT_RUN);
        flags.man_done  = man_done;
        flags.answered  = w_out || !hv_reg[w_idx];
        flags.scan_end  = scan_end;
        flags.decided   = match_m || match_h;
        flags.last_man  = last_man;
        flags.emit_last = out_free && last_man;
    end

    // next-state logic, one operation per control word
    always_comb begin
        pc_next       = pc_reg;
        n_next        = n_reg;
        outer_next    = outer_reg;
        m_next        = m_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        pos_next      = pos_reg;
        np_next       = np_reg;
        hv_next       = hv_reg;
        hb_next       = hb_reg;
        wv_next       = wv_reg;
        wf_next       = wf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (cfg_valid) begin
            pc_next = cfg_data;
        end

        case (uword.op)
            OP_INIT: begin
                n_next     = n_calc;
                outer_next = '0;
                for (int i = 0; i < MAX_PEOPLE; i++) begin
                    np_next[i] = '0;
                    hv_next[i] = 1'b0;
                    wv_next[i] = 1'b0;
                end
            end
            OP_START: begin
                m_next = outer_reg;
            end
            OP_PROPOSE: begin
                if (!man_done) begin
                    np_next[m_reg] = np_reg[m_reg] + NW'(1);
                end
            end
            OP_ANSWER: begin
                // free woman accepts; engaged one starts the rank scan
                w_next = w_idx;
                if (!w_out && !hv_reg[w_idx]) begin
                    hv_next[w_idx] = 1'b1;
                    hb_next[w_idx] = m_reg;
                    wv_next[m_reg] = 1'b1;
                    wf_next[m_reg] = w_idx;
                end else if (!w_out) begin
                    h_next   = hb_reg[w_idx];
                    pos_next = '0;
                end
            end
            OP_SCAN: begin
                if (!scan_end) begin
                    pos_next = pos_reg + NW'(1);
                end
            end
            OP_COMPARE: begin
                // new man found first in her list: swap, dropped man proposes
                if (match_m) begin
                    wv_next[h_reg] = 1'b0;
                    hb_next[w_reg] = m_reg;
                    wv_next[m_reg] = 1'b1;
                    wf_next[m_reg] = w_reg;
                    m_next         = h_reg;
                end
            end
            OP_NEXT: begin
                outer_next = last_man ? '0 : outer_reg + PW'(1);
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {wife_wide[3:0], man_wide[3:0]};
                    m_tlast_next  = last_man;
                    if (!last_man) begin
                        outer_next = outer_reg + PW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PAIR_CNT_RESET;
            n_reg        <= MAXN;
            outer_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_PEOPLE; i++) begin
                np_reg[i] <= '0;
                hv_reg[i] <= 1'b0;
                wv_reg[i] <= 1'b0;
            end
        end else begin
            pc_reg       <= pc_next;
            n_reg        <= n_next;
            outer_reg    <= outer_next;
            m_tvalid_reg <= m_tvalid_next;
            np_reg       <= np_next;
            hv_reg       <= hv_next;
            wv_reg       <= wv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_reg       <= m_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        pos_reg     <= pos_next;
        hb_reg      <= hb_next;
        wf_reg      <= wf_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // man list store: load write port, registered proposal read
    always_ff @(posedge aclk) begin
        if (ld_man_we) begin
            man_mem[ld_addr] <= ld_choice;
        end
        if (prop_en) begin
            man_rd_reg <= man_mem[prop_addr];
        end
    end

    // woman list store: load write port, registered rank scan read
    always_ff @(posedge aclk) begin
        if (ld_woman_we) begin
            woman_mem[ld_addr] <= ld_choice;
        end
        if (scan_en) begin
            woman_rd_reg <= woman_mem[scan_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // a result beat only appears out of the emit step
    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(uword.op == OP_EMIT))
        else $error("result beat raised outside emit step");

    // a run beat closes the input until the run is over
    a_run_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_tuser == ACT_RUN) |=> !s_tready)
        else $error("input still open after run beat");

    // the latched count stays in range for the whole run
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op != OP_IDLE && uword.op != OP_INIT) |-> (n_reg != '0 && n_reg <= MAXN))
        else $error("pair count out of range during run");

    // an engaged proposer is recorded as her husband
    a_engaged_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == OP_PROPOSE && wv_reg[m_reg])
            |-> (hv_reg[wf_reg[m_reg]] && hb_reg[wf_reg[m_reg]] == m_reg))
        else $error("engagement records disagree");

    // after a swap the dropped man proposes next and is free
    a_swap_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == OP_COMPARE && match_m) |=> (!wv_reg[m_reg] && uword.op == OP_PROPOSE))
        else $error("dropped man not freed after swap");
`endif

endmodule

### sv/stable_matching_proposer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_matching_proposer_unit: man-proposing stable matching engine
// Microcoded sequencer driving a datapath with two preference list stores.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: s_tuser picks the action (load man list entry, load woman
//   list entry, run). Load beats are taken one per cycle while idle and
//   write one list entry; they produce no result. A run beat closes s_tready
//   until the last pair of the run has been placed in the m_* output register.
//   m_* channel: one beat per man, in man order, tlast on the final pair.
//   cfg_* channel: pair_count, always ready; write it only while idle.
// Steps of a run: a setup step, then for each man a start step, a propose and
//   an answer step per proposal, a scan and a compare step per position read
//   from an engaged woman's list (the woman store has a single read port), a
//   last scan step when her scan runs through all n positions, a final test
//   and an advance step; after the last man, n result beats at one per cycle
//   while m_tready stays high.
// Reset: pair_count returns to 16, all engagements clear, output empty;
//   list stores keep their contents and must be loaded before a run.
// Stall: a low m_tready freezes the emit step; the pending pair stays on
//   m_tdata, the sequencer waits and s_tready stays low.
// ----------------------------------------------------------------------------
module stable_matching_proposer_unit #(
    parameter int MAX_PEOPLE = smp_pkg::DEF_MAX_PEOPLE
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [smp_pkg::PAIR_CNT_W-1:0]  cfg_data,  // pair_count
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smp_pkg::S_TDATA_W-1:0]   s_tdata,   // person, rank_slot, choice
    input  logic [smp_pkg::ACT_W-1:0]       s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smp_pkg::M_TDATA_W-1:0]   m_tdata,   // man_index, woman_index
    output logic                            m_tlast    // last_pair
);
    import smp_pkg::*;

    uword_t uword;
    flags_t flags;

    // microprogram control
    smp_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    // stores, matching state and ports
    smp_datapath #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .uword     (uword),
        .flags     (flags),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stable_matching_proposer_unit
// Loads man and woman preference lists over the s_ stream, starts matching
// runs under several pair counts and compares every pair on the m_ stream
// against a local man-proposing matching solver that tracks the same lists.
// Both stream sides idle in random bursts; the receiver also holds off once
// for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import smp_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PEOPLE     = DEF_MAX_PEOPLE;
    localparam int LONG_STALL = 300;
    localparam int RAND_ITEMS = 230;
    localparam int RAND_MAX_N = 8;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [CHOICE_W-1:0] person;
        logic [CHOICE_W-1:0] slot;
        logic [CHOICE_W-1:0] choice;
    } beat_t;

    typedef struct packed {
        logic [CHOICE_W-1:0] man;
        logic [CHOICE_W-1:0] woman;
        logic                last;
    } pair_t;

    // DUT ports, inputs all known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [PAIR_CNT_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // person, rank_slot, choice
    logic [ACT_W-1:0]      s_tuser   = '0;  // action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // man_index, woman_index
    logic                  m_tlast;         // last_pair

    // bench state
    beat_t                 pending_beats[$];
    pair_t                 pending_pairs[$];
    logic [CHOICE_W-1:0]   man_pref   [PEOPLE][PEOPLE];
    logic [CHOICE_W-1:0]   woman_pref [PEOPLE][PEOPLE];
    logic [PAIR_CNT_W-1:0] pair_cfg = PAIR_CNT_RESET;
    int                    beats_queued = 0;
    int                    beats_taken  = 0;
    int                    stim_count   = 0;
    int                    errors       = 0;
    int                    idle_pct     = 0;
    bit                    stall_armed  = 1'b0;
    bit                    stall_done   = 1'b0;
    int                    s_gap        = 0;
    int                    r_gap        = 0;
    int                    stall_left   = 0;

    stable_matching_proposer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // position of a man in a woman's list, n when he is not among the first n
    function automatic int rank_in_list(int w, int m, int n);
        for (int i = 0; i < n; i++) begin
            if (woman_pref[w][i] == m[CHOICE_W-1:0]) return i;
        end
        return n;
    endfunction

    // man-proposing matching over the current lists, queues one pair per man
    task automatic solve_matching();
        int    n, cur, w, h;
        bit    wife_ok   [PEOPLE];
        int    wife_id   [PEOPLE];
        bit    husb_ok   [PEOPLE];
        int    husb_id   [PEOPLE];
        int    next_slot [PEOPLE];
        pair_t p;
        if (pair_cfg == 0)
            n = 1;
        else if (pair_cfg > PEOPLE)
            n = PEOPLE;
        else
            n = pair_cfg;
        for (int k = 0; k < PEOPLE; k++) begin
            wife_ok[k]   = 1'b0;
            wife_id[k]   = 0;
            husb_ok[k]   = 1'b0;
            husb_id[k]   = 0;
            next_slot[k] = 0;
        end
        for (int m = 0; m < n; m++) begin
            cur = m;
            while (!wife_ok[cur] && next_slot[cur] < n) begin
                w = man_pref[cur][next_slot[cur]];
                next_slot[cur]++;
                // a woman outside the run rejects outright
                if (w < n) begin
                    if (!husb_ok[w]) begin
                        husb_ok[w]   = 1'b1;
                        husb_id[w]   = cur;
                        wife_ok[cur] = 1'b1;
                        wife_id[cur] = w;
                    end else begin
                        h = husb_id[w];
                        // strictly earlier wins; a tie keeps the present partner
                        if (rank_in_list(w, cur, n) < rank_in_list(w, h, n)) begin
                            wife_ok[h]   = 1'b0;
                            wife_id[h]   = 0;
                            husb_id[w]   = cur;
                            wife_ok[cur] = 1'b1;
                            wife_id[cur] = w;
                            cur          = h;
                        end
                    end
                end
            end
        end
        for (int m = 0; m < n; m++) begin
            p.man   = CHOICE_W'(m);
            p.woman = wife_ok[m] ? CHOICE_W'(wife_id[m]) : '0;
            p.last  = (m == n - 1);
            pending_pairs.push_back(p);
        end
    endtask

    // input driver: holds a beat until taken, idles in short bursts
    always @(posedge aclk) begin : drive_beats
        beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap    <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_gap != 0) begin
                s_gap    <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                s_gap    <= $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                nxt      = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.action;
                s_tdata  <= {4'b0, nxt.choice, nxt.slot, nxt.person};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            r_gap      <= 0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_armed && !stall_done && m_tvalid &&
                     (s_tvalid || pending_beats.size() != 0)) begin
            stall_left <= LONG_STALL;
            stall_done <= 1'b1;
            m_tready   <= 1'b0;
        end else if (r_gap != 0) begin
            r_gap    <= r_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            r_gap    <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: tracks config and list writes, checks every pair beat
    always @(posedge aclk) begin : check_pairs
        pair_t seen, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                pair_cfg = cfg_data;
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    ACT_LOAD_MAN:   man_pref[s_tdata[3:0]][s_tdata[7:4]]   = s_tdata[11:8];
                    ACT_LOAD_WOMAN: woman_pref[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[11:8];
                    ACT_RUN:        solve_matching();
                    default: ;
                endcase
                beats_taken++;
            end
            if (m_tvalid && m_tready) begin
                seen.man   = m_tdata[3:0];
                seen.woman = m_tdata[7:4];
                seen.last  = m_tlast;
                if (pending_pairs.size() == 0) begin
                    $display("%0t: unexpected pair, got man %0d woman %0d last %0b",
                             $time, seen.man, seen.woman, seen.last);
                    errors++;
                end else begin
                    want = pending_pairs.pop_front();
                    if (seen.man !== want.man) begin
                        $display("%0t: man_index expected %0d, got %0d",
                                 $time, want.man, seen.man);
                        errors++;
                    end
                    if (seen.woman !== want.woman) begin
                        $display("%0t: woman_index of man %0d expected %0d, got %0d",
                                 $time, want.man, want.woman, seen.woman);
                        errors++;
                    end
                    if (seen.last !== want.last) begin
                        $display("%0t: last_pair of man %0d expected %0b, got %0b",
                                 $time, want.man, want.last, seen.last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_beat(logic [ACT_W-1:0] act, int person, int slot, int choice);
        beat_t b;
        b.action = act;
        b.person = CHOICE_W'(person);
        b.slot   = CHOICE_W'(slot);
        b.choice = CHOICE_W'(choice);
        pending_beats.push_back(b);
        beats_queued++;
        if (act != ACT_UNUSED) stim_count++;
    endtask

    task automatic push_run();
        push_beat(ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15));
    endtask

    // one list row holding a shuffled set of 0..len-1 in slots 0..len-1
    task automatic push_row(logic [ACT_W-1:0] act, int person, int len);
        int perm [PEOPLE];
        int j, t;
        for (int i = 0; i < len; i++) perm[i] = i;
        for (int i = len - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < len; i++) push_beat(act, person, i, perm[i]);
    endtask

    // three-entry row, slot 0 in the low nibble
    task automatic push_row3(logic [ACT_W-1:0] act, int person, logic [11:0] row);
        for (int i = 0; i < 3; i++) push_beat(act, person, i, row[4*i +: 4]);
    endtask

    task automatic refill_lists(int n);
        for (int p = 0; p < n; p++) begin
            push_row(ACT_LOAD_MAN, p, n);
            push_row(ACT_LOAD_WOMAN, p, n);
        end
    endtask

    // all beats taken, all pairs seen, then a short settle
    task automatic wait_drained();
        do @(posedge aclk);
        while (beats_taken != beats_queued || pending_pairs.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_pair_count(int value);
        wait_drained();
        cfg_data  <= PAIR_CNT_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        int code, cfg, n, segs, rows, noise, base;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        idle_pct = 10;

        // man p names woman p first: full-size runs settle on the first
        // proposal of each man and read no other list entry
        for (int p = 0; p < PEOPLE; p++) push_beat(ACT_LOAD_MAN, p, 0, p);
        push_run();                          // pair count straight from reset
        push_beat(ACT_UNUSED, 15, 15, 15);   // unused action, must change nothing
        push_beat(ACT_UNUSED, 0, 0, 0);
        push_run();
        set_pair_count(0);                   // zero acts as one
        push_run();
        set_pair_count(31);                  // saturates to full size
        push_run();
        set_pair_count(17);
        push_run();

        // three pairs: a switch, a rejected out-of-run woman, a tie kept,
        // men missing from lists
        set_pair_count(3);
        push_row3(ACT_LOAD_MAN, 0, 12'h170);
        push_row3(ACT_LOAD_MAN, 1, 12'h120);
        push_row3(ACT_LOAD_MAN, 2, 12'h210);
        push_row3(ACT_LOAD_WOMAN, 0, 12'h155);
        push_row3(ACT_LOAD_WOMAN, 1, 12'h555);
        push_row3(ACT_LOAD_WOMAN, 2, 12'h022);
        push_run();
        set_pair_count(1);
        push_run();

        // full lists for every pair count the random phases use
        refill_lists(RAND_MAX_N);

        // random phases: a pair count, then load/run segments
        base        = stim_count;
        stall_armed = 1'b1;
        while (stim_count - base < RAND_ITEMS) begin
            code = $urandom_range(0, 99);
            if (code < 8)
                cfg = $urandom_range(0, 1);
            else if (code < 75)
                cfg = $urandom_range(2, 6);
            else
                cfg = $urandom_range(7, RAND_MAX_N);
            n = (cfg == 0) ? 1 : cfg;
            code = $urandom_range(0, 2);
            idle_pct = (code == 0) ? 0 : (code == 1) ? 10 : 35;
            set_pair_count(cfg);
            if ($urandom_range(0, 9) < 7)
                refill_lists(n);
            segs = $urandom_range(2, 5);
            repeat (segs) begin
                rows = $urandom_range(0, 2);
                repeat (rows) begin
                    push_row($urandom_range(0, 1) ? ACT_LOAD_WOMAN : ACT_LOAD_MAN,
                             $urandom_range(0, n - 1),
                             ($urandom_range(0, 4) == 0) ? PEOPLE : n);
                end
                noise = $urandom_range(0, 3);
                repeat (noise) begin
                    if ($urandom_range(0, 4) == 0)
                        push_beat(ACT_UNUSED, $urandom_range(0, 15),
                                  $urandom_range(0, 15), $urandom_range(0, 15));
                    else
                        push_beat($urandom_range(0, 1) ? ACT_LOAD_WOMAN : ACT_LOAD_MAN,
                                  $urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom_range(0, 15));
                end
                push_run();
            end
        end

        // closing phase without any idling
        idle_pct = 0;
        set_pair_count(5);
        repeat (3) begin
            push_row(ACT_LOAD_MAN, $urandom_range(0, 4), 5);
            push_run();
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_pairs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
sv/smp_pkg.sv
sv/smp_sequencer.sv
sv/smp_datapath.sv
sv/stable_matching_proposer_unit.sv
tb/testbench.sv
